// File: design/spq_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the stable priority queue
// no dependencies; used by spq_cell and stable_priority_queue

package spq_pkg;

   // result status codes
   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_SERVED   = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // request kind carried in tuser
   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_SERVE   = 1'b1;

   // per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic enq;
      logic deq;
   } cell_ctrl_type;

endpackage

// File: design/spq_cell.sv
`timescale 1ns / 1ps
// one slot of the sorted insertion chain: holds an entry and trades with its neighbors
// depends on spq_pkg

module spq_cell #(
   parameter int PRIORITY_BITS = 8,
   parameter int PAYLOAD_BITS  = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  spq_pkg::cell_ctrl_type     ctrl,
   input  logic [PRIORITY_BITS-1:0]   new_prio,
   input  logic [PAYLOAD_BITS-1:0]    new_pay,
   // left neighbor (toward the head)
   input  logic                       prev_after,
   input  logic                       prev_valid,
   input  logic [PRIORITY_BITS-1:0]   prev_prio,
   input  logic [PAYLOAD_BITS-1:0]    prev_pay,
   // right neighbor (toward the tail)
   input  logic                       next_valid,
   input  logic [PRIORITY_BITS-1:0]   next_prio,
   input  logic [PAYLOAD_BITS-1:0]    next_pay,
   // held entry
   output logic                       valid,
   output logic [PRIORITY_BITS-1:0]   prio,
   output logic [PAYLOAD_BITS-1:0]    pay,
   output logic                       after
);

   logic                     valid_ff, valid_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic [PAYLOAD_BITS-1:0]  pay_ff, pay_in;

   // new entry goes behind this one when priorities tie
   assign after = valid_ff && (prio_ff <= new_prio);

   always_comb begin
      valid_in = valid_ff;
      prio_in  = prio_ff;
      pay_in   = pay_ff;
      priority if (ctrl.enq) begin
         if (!after) begin
            if (prev_after) begin
               valid_in = 1'b1;
               prio_in  = new_prio;
               pay_in   = new_pay;
            end else begin
               valid_in = prev_valid;
               prio_in  = prev_prio;
               pay_in   = prev_pay;
            end
         end
      end else if (ctrl.deq) begin
         valid_in = next_valid;
         prio_in  = next_prio;
         pay_in   = next_pay;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prio_ff <= prio_in;
      pay_ff  <= pay_in;
   end

   assign valid = valid_ff;
   assign prio  = prio_ff;
   assign pay   = pay_ff;

endmodule

// File: design/stable_priority_queue.sv
`timescale 1ns / 1ps
// stable priority queue: the response to an accepted request is registered in the next cycle
// 1 op per cycle unless rsp_tready stalls; each is one parallel compare and shift of the chain
// the output register frees in the same cycle it is taken, so back-pressure costs no bubble
// reset (synchronous, active high) empties the chain and the response register
// depends on spq_pkg and spq_cell

module stable_priority_queue #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int PAYLOAD_BITS  = 32
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic req_tvalid,
   output logic req_tready,
   // fields from bit 0: priority_req, item_payload, zero fill
   input  logic [((PRIORITY_BITS+PAYLOAD_BITS+7)/8)*8-1:0] req_tdata,
   // fields from bit 0: mode
   input  logic req_tuser,
   // response channel
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // fields from bit 0: served_priority, served_payload, occupancy, is_empty, zero fill
   output logic [((PRIORITY_BITS+PAYLOAD_BITS+$clog2(CAPACITY+1)+1+7)/8)*8-1:0] rsp_tdata,
   // fields from bit 0: status
   output logic [1:0] rsp_tuser
);

   localparam int OCC_BITS   = $clog2(CAPACITY + 1);
   localparam int RSP_FIELDS = PRIORITY_BITS + PAYLOAD_BITS + OCC_BITS + 1;
   localparam int RSP_BITS   = ((RSP_FIELDS + 7) / 8) * 8;

   // request unpacking
   logic                     mode;
   logic [PRIORITY_BITS-1:0] new_prio;
   logic [PAYLOAD_BITS-1:0]  new_pay;
   logic                     accept;

   assign mode     = req_tuser;
   assign new_prio = req_tdata[PRIORITY_BITS-1:0];
   assign new_pay  = req_tdata[PRIORITY_BITS+PAYLOAD_BITS-1:PRIORITY_BITS];

   // cell chain wiring
   logic                     cell_valid [CAPACITY];
   logic [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];
   logic [PAYLOAD_BITS-1:0]  cell_pay   [CAPACITY];
   logic                     cell_after [CAPACITY];
   spq_pkg::cell_ctrl_type   ctrl;

   logic full, empty;
   assign full  = cell_valid[CAPACITY-1];
   assign empty = !cell_valid[0];

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type       status_ff, status_in;
   logic [PRIORITY_BITS-1:0]  s_prio_ff, s_prio_in;
   logic [PAYLOAD_BITS-1:0]   s_pay_ff, s_pay_in;
   logic [OCC_BITS-1:0]       fill_ff, fill_in;
   logic                      empty_out_ff, empty_out_in;

   // a new transaction may enter whenever the response slot is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // only real changes reach the cells: a full enqueue or empty serve leaves them alone
   assign ctrl.enq = accept && (mode == spq_pkg::MODE_ENQUEUE) && !full;
   assign ctrl.deq = accept && (mode == spq_pkg::MODE_SERVE) && !empty;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic                     p_after, p_valid, n_valid;
         logic [PRIORITY_BITS-1:0] p_prio, n_prio;
         logic [PAYLOAD_BITS-1:0]  p_pay, n_pay;

         if (g == 0) begin : g_head
            // the head always takes the new entry unless it stays ahead of it
            assign p_after = 1'b1;
            assign p_valid = 1'b0;
            assign p_prio  = '0;
            assign p_pay   = '0;
         end else begin : g_mid
            assign p_after = cell_after[g-1];
            assign p_valid = cell_valid[g-1];
            assign p_prio  = cell_prio[g-1];
            assign p_pay   = cell_pay[g-1];
         end

         if (g == CAPACITY - 1) begin : g_tail
            // the tail empties on a serve
            assign n_valid = 1'b0;
            assign n_prio  = '0;
            assign n_pay   = '0;
         end else begin : g_body
            assign n_valid = cell_valid[g+1];
            assign n_prio  = cell_prio[g+1];
            assign n_pay   = cell_pay[g+1];
         end

         spq_cell #(
            .PRIORITY_BITS (PRIORITY_BITS),
            .PAYLOAD_BITS  (PAYLOAD_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .new_prio   (new_prio),
            .new_pay    (new_pay),
            .prev_after (p_after),
            .prev_valid (p_valid),
            .prev_prio  (p_prio),
            .prev_pay   (p_pay),
            .next_valid (n_valid),
            .next_prio  (n_prio),
            .next_pay   (n_pay),
            .valid      (cell_valid[g]),
            .prio       (cell_prio[g]),
            .pay        (cell_pay[g]),
            .after      (cell_after[g])
         );
      end
   endgenerate

   // response formation, evaluated in the accept cycle
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      s_prio_in    = s_prio_ff;
      s_pay_in     = s_pay_ff;
      fill_in      = fill_ff;
      empty_out_in = empty_out_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         s_prio_in    = '0;
         s_pay_in     = '0;
         priority if (ctrl.enq) begin
            status_in = spq_pkg::ST_ENQUEUED;
            fill_in   = fill_ff + OCC_BITS'(1);
         end else if (ctrl.deq) begin
            status_in = spq_pkg::ST_SERVED;
            s_prio_in = cell_prio[0];
            s_pay_in  = cell_pay[0];
            fill_in   = fill_ff - OCC_BITS'(1);
         end else if (mode == spq_pkg::MODE_SERVE) begin
            status_in = spq_pkg::ST_EMPTY;
         end else begin
            status_in = spq_pkg::ST_FULL;
         end
         empty_out_in = (fill_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
      status_ff    <= status_in;
      s_prio_ff    <= s_prio_in;
      s_pay_ff     <= s_pay_in;
      empty_out_ff <= empty_out_in;
   end

   // response packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = RSP_BITS'({empty_out_ff, fill_ff, s_pay_ff, s_prio_ff});

endmodule

// File: bench/stable_priority_queue_test.sv
`timescale 1ns / 1ps
// self-checking bench for stable_priority_queue: a shadow sorted queue predicts every response
// depends on spq_pkg and the stable_priority_queue rtl

module stable_priority_queue_test;

   localparam int CAPACITY         = 16;
   localparam int PRIORITY_BITS    = 8;
   localparam int PAYLOAD_BITS     = 32;
   localparam int OCC_BITS         = $clog2(CAPACITY + 1);
   localparam int REQ_BITS         = ((PRIORITY_BITS + PAYLOAD_BITS + 7) / 8) * 8;
   localparam int RSP_BITS         = ((PRIORITY_BITS + PAYLOAD_BITS + OCC_BITS + 1 + 7) / 8) * 8;
   // response field offsets inside rsp_tdata
   localparam int PAY_LSB          = PRIORITY_BITS;
   localparam int OCC_LSB          = PRIORITY_BITS + PAYLOAD_BITS;
   localparam int EMPTY_BIT        = OCC_LSB + OCC_BITS;
   localparam int ITEM_TARGET      = 1300;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int HOLD_SPACING     = 400;
   localparam int TAIL_CYCLES      = 10;
   localparam int MAX_REPORTS      = 10;

   typedef struct packed {
      logic                     mode;
      logic [PRIORITY_BITS-1:0] prio;
      logic [PAYLOAD_BITS-1:0]  payload;
   } queue_op_type;

   typedef struct packed {
      spq_pkg::status_type      status;
      logic [PRIORITY_BITS-1:0] served_prio;
      logic [PAYLOAD_BITS-1:0]  served_payload;
      logic [OCC_BITS-1:0]      occupancy;
      logic                     is_empty;
   } queue_outcome_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   // fields from bit 0: priority_req, item_payload, zero fill
   logic [REQ_BITS-1:0] req_tdata  = '0;
   // fields from bit 0: mode
   logic                req_tuser  = spq_pkg::MODE_ENQUEUE;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // fields from bit 0: served_priority, served_payload, occupancy, is_empty, zero fill
   logic [RSP_BITS-1:0] rsp_tdata;
   // fields from bit 0: status
   logic [1:0]          rsp_tuser;

   // shadow copy of the sorted store, head at index 0
   logic [PRIORITY_BITS-1:0] shadow_prio    [CAPACITY];
   logic [PAYLOAD_BITS-1:0]  shadow_payload [CAPACITY];
   int                       shadow_fill = 0;

   queue_op_type      pending_ops[$];        // transactions not yet offered
   queue_outcome_type expected_outcomes[$];  // predictions awaiting their response

   int   mismatch_count = 0;
   int   responses_seen = 0;
   int   idle_cycles    = 0;
   logic hold_active    = 1'b0;  // receiver is in its long hold-off

   stable_priority_queue #(
      .CAPACITY      (CAPACITY),
      .PRIORITY_BITS (PRIORITY_BITS),
      .PAYLOAD_BITS  (PAYLOAD_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // apply one transaction to the shadow queue and return the response it must produce
   task automatic apply_queue_op(input queue_op_type op, output queue_outcome_type res);
      int pos;
      int i;
      res.status         = spq_pkg::ST_ENQUEUED;
      res.served_prio    = '0;
      res.served_payload = '0;
      if (op.mode == spq_pkg::MODE_ENQUEUE) begin
         if (shadow_fill >= CAPACITY) begin
            res.status = spq_pkg::ST_FULL;  // dropped, store untouched
         end else begin
            // stable insert: go past every entry with priority <= ours
            pos = 0;
            while (pos < shadow_fill && shadow_prio[pos] <= op.prio) pos++;
            for (i = shadow_fill; i > pos; i--) begin
               shadow_prio[i]    = shadow_prio[i-1];
               shadow_payload[i] = shadow_payload[i-1];
            end
            shadow_prio[pos]    = op.prio;
            shadow_payload[pos] = op.payload;
            shadow_fill++;
         end
      end else if (shadow_fill == 0) begin
         res.status = spq_pkg::ST_EMPTY;
      end else begin
         res.status         = spq_pkg::ST_SERVED;
         res.served_prio    = shadow_prio[0];
         res.served_payload = shadow_payload[0];
         for (i = 1; i < shadow_fill; i++) begin
            shadow_prio[i-1]    = shadow_prio[i];
            shadow_payload[i-1] = shadow_payload[i];
         end
         shadow_fill--;
      end
      res.occupancy = OCC_BITS'(shadow_fill);
      res.is_empty  = (shadow_fill == 0);
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch in %s: expected %0h, actual %0h", name, want, got);
      end
   endtask

   // idle length between transactions: mostly none or short, now and then long
   function automatic int idle_length(input int quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet != 0) return 0;
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // occasional stretches of back-to-back transactions with no idling
   function automatic int next_quiet(input int quiet);
      if (quiet != 0) return quiet - 1;
      return ($urandom_range(0, 59) == 0) ? 40 : 0;
   endfunction

   function automatic logic [PRIORITY_BITS-1:0] random_prio();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return PRIORITY_BITS'($urandom_range(0, 3));  // dense ties
      if (r == 4) return '0;
      if (r == 5) return '1;
      return PRIORITY_BITS'($urandom);
   endfunction

   function automatic logic [PAYLOAD_BITS-1:0] random_payload();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return PAYLOAD_BITS'($urandom);
   endfunction

   task automatic add_op(input logic mode, input logic [PRIORITY_BITS-1:0] prio,
                         input logic [PAYLOAD_BITS-1:0] payload);
      queue_op_type op;
      op.mode    = mode;
      op.prio    = prio;
      op.payload = payload;
      pending_ops.push_back(op);
   endtask

   // stimulus, reset and end of run
   initial begin : sequencer
      int n;
      int phase_len;
      int enq_pct;
      n = 0;

      // directed: serve on empty, field extremes, ties, fill to full, drop, partial drain
      add_op(spq_pkg::MODE_SERVE, '1, '1);
      add_op(spq_pkg::MODE_ENQUEUE, '1, '1);
      add_op(spq_pkg::MODE_ENQUEUE, '0, '0);
      add_op(spq_pkg::MODE_ENQUEUE, 8'h80, 32'h0000_0001);
      add_op(spq_pkg::MODE_ENQUEUE, 8'h80, 32'h0000_0002);
      add_op(spq_pkg::MODE_ENQUEUE, 8'h80, 32'h0000_0003);
      add_op(spq_pkg::MODE_ENQUEUE, '0, 32'hA5A5_5A5A);  // tie at the head
      for (int i = 0; i < CAPACITY - 6; i++)
         add_op(spq_pkg::MODE_ENQUEUE, PRIORITY_BITS'(i * 23 + 7), random_payload());
      add_op(spq_pkg::MODE_ENQUEUE, 8'h01, 32'hDEAD_BEEF);  // queue is full here
      repeat (6) add_op(spq_pkg::MODE_SERVE, '0, '0);
      n = pending_ops.size();

      // random phases; the enqueue share varies so the fill level sweeps empty to full
      while (n < ITEM_TARGET) begin
         phase_len = $urandom_range(20, 60);
         case ($urandom_range(0, 4))
            0: enq_pct = 10;
            1: enq_pct = 50;
            2: enq_pct = 70;
            3: enq_pct = 95;
            default: enq_pct = 30;
         endcase
         repeat (phase_len) begin
            if ($urandom_range(0, 99) < enq_pct)
               add_op(spq_pkg::MODE_ENQUEUE, random_prio(), random_payload());
            else
               add_op(spq_pkg::MODE_SERVE, PRIORITY_BITS'($urandom), PAYLOAD_BITS'($urandom));
            n++;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // everything offered, accepted and answered
      while (pending_ops.size() != 0 || req_tvalid || expected_outcomes.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // driver: predicts on each accepted transaction, then offers the next one
   always @(posedge clock) begin : driver
      queue_op_type      accepted_op;
      queue_op_type      next_op;
      queue_outcome_type predicted;
      int                send_idle;
      int                send_quiet;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_idle  = 0;
         send_quiet = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            accepted_op.mode    = req_tuser;
            accepted_op.prio    = req_tdata[PRIORITY_BITS-1:0];
            accepted_op.payload = req_tdata[PAY_LSB +: PAYLOAD_BITS];
            apply_queue_op(accepted_op, predicted);
            expected_outcomes.push_back(predicted);
         end
         if (!req_tvalid || req_tready) begin
            // no gaps while the receiver holds off, so the block fills and stalls
            if (send_idle != 0 && !hold_active) begin
               send_idle = send_idle - 1;
               req_tvalid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
               next_op = pending_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_op.mode;
               req_tdata  <= REQ_BITS'({next_op.payload, next_op.prio});
               send_idle  = idle_length(send_quiet);
               send_quiet = next_quiet(send_quiet);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver ready: random stalls plus two long hold-offs
   always @(posedge clock) begin : receiver
      int recv_idle;
      int recv_quiet;
      int hold_left;
      int holds_done;
      if (reset) begin
         rsp_tready  <= 1'b0;
         hold_active <= 1'b0;
         recv_idle   = 0;
         recv_quiet  = 0;
         hold_left   = 0;
         holds_done  = 0;
      end else if (hold_left != 0) begin
         hold_left   = hold_left - 1;
         hold_active <= (hold_left != 0);
         rsp_tready  <= (hold_left == 0);
      end else if (holds_done < 2 && responses_seen >= HOLD_SPACING * (holds_done + 1)) begin
         holds_done  = holds_done + 1;
         hold_left   = LONG_HOLD_CYCLES;
         hold_active <= 1'b1;
         rsp_tready  <= 1'b0;
      end else if (recv_idle != 0) begin
         recv_idle  = recv_idle - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         recv_idle  = idle_length(recv_quiet);
         recv_quiet = next_quiet(recv_quiet);
      end
   end

   // monitor: each response against the oldest prediction, field by field
   always @(posedge clock) begin : monitor
      queue_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen <= responses_seen + 1;
         if (expected_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("response with no transaction pending: tuser %0h, tdata %0h",
                        rsp_tuser, rsp_tdata);
         end else begin
            want = expected_outcomes.pop_front();
            check_field("status", want.status, rsp_tuser);
            check_field("served_priority", want.served_prio, rsp_tdata[PRIORITY_BITS-1:0]);
            check_field("served_payload", want.served_payload,
                        rsp_tdata[PAY_LSB +: PAYLOAD_BITS]);
            check_field("occupancy", want.occupancy, rsp_tdata[OCC_LSB +: OCC_BITS]);
            check_field("is_empty", want.is_empty, rsp_tdata[EMPTY_BIT]);
         end
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// File: files.f
design/spq_pkg.sv
design/spq_cell.sv
design/stable_priority_queue.sv
bench/stable_priority_queue_test.sv
